// ----- design/hsv_pkg.sv -----
package hsv_pkg;

  // fixed point format of saturation, value and the color outputs
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int HUE_BITS  = 16;
  localparam int UP_SHIFT   = (FRAC_BITS >= HUE_BITS) ? (FRAC_BITS - HUE_BITS) : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS >= HUE_BITS) ? 0 : (HUE_BITS - FRAC_BITS);
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  // hue sectors, named by the color at the start of each sixth of a turn
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [Q_W-1:0]      saturation;
    logic [Q_W-1:0]      value;
  } hsv_pixel_t;

  typedef struct packed {
    logic [Q_W-1:0] red;
    logic [Q_W-1:0] green;
    logic [Q_W-1:0] blue;
  } rgb_pixel_t;

  // decoded pixel after the first stage
  typedef struct packed {
    logic                 valid;
    logic                 grey;
    sector_t              sector;
    logic [FRAC_BITS-1:0] frac;
    logic [Q_W-1:0]       sat;
    logic [Q_W-1:0]       val;
  } hsv_front_t;

  // products after the last multiply stage
  typedef struct packed {
    logic           valid;
    logic           grey;
    sector_t        sector;
    logic [Q_W-1:0] val;
    logic [Q_W-1:0] p;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] t;
  } hsv_prod_t;

  function automatic logic [Q_W-1:0] clamp_one(input logic [Q_W-1:0] x);
    clamp_one = (x > ONE_Q) ? ONE_Q : x;
  endfunction

endpackage

// ----- design/hsv_front.sv -----
module hsv_front import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  hsv_pixel_t pixel,
  output hsv_front_t front
);

  localparam int SCALED_W = HUE_BITS + 3;
  localparam int UP_W     = HUE_BITS + UP_SHIFT;

  logic [SCALED_W-1:0]  scaled;
  logic [HUE_BITS-1:0]  hue_frac;
  logic [UP_W-1:0]      frac_up;
  logic [Q_W-1:0]       sat_c;
  logic [Q_W-1:0]       val_c;

  // hue * 6 as hue * 4 + hue * 2
  assign scaled   = (SCALED_W'(pixel.hue) << 2) + (SCALED_W'(pixel.hue) << 1);
  assign hue_frac = scaled[HUE_BITS-1:0];
  assign frac_up  = UP_W'(hue_frac) << UP_SHIFT;
  assign sat_c    = clamp_one(pixel.saturation);
  assign val_c    = clamp_one(pixel.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= in_valid;
    end
    front.grey   <= (sat_c == '0);
    front.sector <= sector_t'(scaled[SCALED_W-1:HUE_BITS]);
    front.frac   <= FRAC_BITS'(frac_up >> DOWN_SHIFT);
    front.sat    <= sat_c;
    front.val    <= val_c;
  end

endmodule

// ----- design/hsv_prod.sv -----
module hsv_prod import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  hsv_front_t front,
  output hsv_prod_t  prod
);

  localparam int PW = 2 * Q_W;

  // first multiply stage: f*s, (1-f)*s, v*(1-s)
  logic [Q_W-1:0] frac_q;
  logic [Q_W-1:0] inv_frac;
  logic [PW-1:0]  fs_full;
  logic [PW-1:0]  gs_full;
  logic [PW-1:0]  p_full;

  logic           m1_valid;
  logic           m1_grey;
  sector_t        m1_sector;
  logic [Q_W-1:0] m1_val;
  logic [Q_W-1:0] m1_fs;
  logic [Q_W-1:0] m1_gs;
  logic [Q_W-1:0] m1_p;

  assign frac_q   = Q_W'(front.frac);
  assign inv_frac = ONE_Q - frac_q;
  assign fs_full  = PW'(frac_q) * PW'(front.sat);
  assign gs_full  = PW'(inv_frac) * PW'(front.sat);
  assign p_full   = PW'(front.val) * PW'(ONE_Q - front.sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= front.valid;
    end
    m1_grey   <= front.grey;
    m1_sector <= front.sector;
    m1_val    <= front.val;
    m1_fs     <= Q_W'(fs_full >> FRAC_BITS);
    m1_gs     <= Q_W'(gs_full >> FRAC_BITS);
    m1_p      <= Q_W'(p_full >> FRAC_BITS);
  end

  // second multiply stage: v*(1-fs), v*(1-gs)
  logic [PW-1:0] q_full;
  logic [PW-1:0] t_full;

  assign q_full = PW'(m1_val) * PW'(ONE_Q - m1_fs);
  assign t_full = PW'(m1_val) * PW'(ONE_Q - m1_gs);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= m1_valid;
    end
    prod.grey   <= m1_grey;
    prod.sector <= m1_sector;
    prod.val    <= m1_val;
    prod.p      <= m1_p;
    prod.q      <= Q_W'(q_full >> FRAC_BITS);
    prod.t      <= Q_W'(t_full >> FRAC_BITS);
  end

endmodule

// ----- design/hsv_route.sv -----
module hsv_route import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  hsv_prod_t  prod,
  output logic       done,
  output rgb_pixel_t color
);

  rgb_pixel_t color_next;

  always_comb begin
    if (prod.grey) begin
      color_next = '{red: prod.val, green: prod.val, blue: prod.val};
    end else begin
      case (prod.sector)
        SEC_RED:    color_next = '{red: prod.val, green: prod.t,   blue: prod.p};
        SEC_YELLOW: color_next = '{red: prod.q,   green: prod.val, blue: prod.p};
        SEC_GREEN:  color_next = '{red: prod.p,   green: prod.val, blue: prod.t};
        SEC_CYAN:   color_next = '{red: prod.p,   green: prod.q,   blue: prod.val};
        SEC_BLUE:   color_next = '{red: prod.t,   green: prod.p,   blue: prod.val};
        default:    color_next = '{red: prod.val, green: prod.p,   blue: prod.q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod.valid;
    end
    color <= color_next;
  end

endmodule

// ----- design/hsv_to_rgb_converter_unit.sv -----
// hsv to rgb converter, six-sector method, fixed point
// a pixel taken with start is registered in the front stage, then in the m1 and prod stages, then in done
// throughput: one pixel per clock, busy is always low, set by the four-stage pipeline
// the receiver cannot stall; each result is shown for exactly one cycle under done
// reset (rst, synchronous, active high) clears the valid bits of all stages
module hsv_to_rgb_converter_unit import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  hsv_pixel_t pixel,
  output logic       busy,
  output logic       done,
  output rgb_pixel_t color
);

  // the pipeline never holds, so a beat is taken on every start
  logic       accept;
  hsv_front_t front;
  hsv_prod_t  prod;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stage 1: clamp s and v, split hue * 6 into sector and fraction
  hsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .pixel    (pixel),
    .front    (front)
  );

  // stages 2 and 3: fs, gs and p, then q and t
  hsv_prod u_prod (
    .clk   (clk),
    .rst   (rst),
    .front (front),
    .prod  (prod)
  );

  // stage 4: route v, p, q, t to the color channels by sector
  hsv_route u_route (
    .clk   (clk),
    .rst   (rst),
    .prod  (prod),
    .done  (done),
    .color (color)
  );

  // a result beat only ever follows an accepted pixel that has passed through the pipeline
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 4))
    else $error("result beat without a matching input beat");

  // every accepted pixel comes out under done
  assert property (@(posedge clk) disable iff (rst) accept |-> ##4 done)
    else $error("accepted pixel lost in the pipeline");

  // zero saturation gives grey
  assert property (@(posedge clk) disable iff (rst)
    done && $past(pixel.saturation == '0, 4)
      |-> (color.red == color.green) && (color.green == color.blue))
    else $error("zero saturation did not give grey");

endmodule
